// ===== rtl/core/cpts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and constants for the counter/priority scheduler
// Holds operation codes, run states, the controller state type and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_INTR    = 2'd1;

  localparam logic [31:0] SIG_ALARM_BIT = 32'h0000_2000;
  localparam logic [31:0] UNBLOCKABLE   = 32'h0004_0100;

  localparam int IN_BITS  = 288;
  localparam int OUT_BITS = 192;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WAKE,
    S_PICK,
    S_REFILL,
    S_PICK2,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic clear;     // reset sweep step
    logic write;     // load slot from input item
    logic read;      // capture readback
    logic sched_start;
    logic wake;      // wake step at scan index
    logic pick;      // pick step at scan index
    logic pick_init;
    logic refill;    // refill step at scan index
    logic set_refill;
  } cpts_cmd_t;

  typedef struct packed {
    logic best_zero; // best counter found is 0
  } cpts_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_ctrl: controller state machine
// Sequences clear sweep, write, read, and the wake/pick/refill scans.
// ----------------------------------------------------------------------------
module cpts_ctrl import cpts_pkg::*; #(
  parameter int NUM_SLOTS = 64,
  parameter int IW = $clog2(NUM_SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic [1:0]    in_op,
  input  wire logic          out_busy,   // result register still full
  input  cpts_sts_t          sts,
  output cpts_cmd_t          cmd,
  output logic [IW-1:0]      idx,
  output logic               in_ready,
  output logic               emit
);

  ctl_state_t state, state_next;
  logic [IW-1:0] idx_next;
  logic last;

  // Scans run down to index 0; that step carries no command and drains the
  // registered action on slot 1.
  assign last = (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= IW'(NUM_SLOTS - 1);
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    in_ready   = 1'b0;
    emit       = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        idx_next  = idx - IW'(1);
        if (idx == '0) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !out_busy;
        idx_next = IW'(NUM_SLOTS - 1);
        if (in_fire) begin
          case (in_op)
            OP_WRITE: cmd.write = 1'b1;
            OP_READ: begin
              cmd.read = 1'b1;
              emit     = 1'b1;
            end
            OP_SCHED: begin
              cmd.sched_start = 1'b1;
              state_next      = S_WAKE;
            end
            default: ;
          endcase
        end
      end
      S_WAKE: begin
        cmd.wake = !last;
        idx_next = idx - IW'(1);
        if (last) begin
          idx_next   = IW'(NUM_SLOTS - 1);
          state_next = S_PICK;
        end
        if (idx == IW'(NUM_SLOTS - 1)) begin
          cmd.pick_init = 1'b1;
        end
      end
      S_PICK: begin
        cmd.pick = !last;
        cmd.pick_init = (idx == IW'(NUM_SLOTS - 1));
        idx_next = idx - IW'(1);
        if (last) begin
          idx_next   = IW'(NUM_SLOTS - 1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.best_zero && !cmd.set_refill) begin
          state_next = S_REFILL;
        end else begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REFILL: begin
        cmd.refill = !last;
        idx_next   = idx - IW'(1);
        if (last) begin
          cmd.set_refill = 1'b1;
          idx_next   = IW'(NUM_SLOTS - 1);
          state_next = S_PICK2;
        end
      end
      S_PICK2: begin
        cmd.pick = !last;
        cmd.pick_init = (idx == IW'(NUM_SLOTS - 1));
        idx_next = idx - IW'(1);
        if (last) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_dp: slot table and scan datapath
// Holds the slot table; a scan registers one slot a cycle and acts on it,
// writing back, in the cycle after.
// ----------------------------------------------------------------------------
module cpts_dp import cpts_pkg::*; #(
  parameter int NUM_SLOTS = 64,
  parameter int IW = $clog2(NUM_SLOTS)
) (
  input  wire logic                clk,
  input  cpts_cmd_t                cmd,
  input  wire logic [IW-1:0]       idx,
  input  wire logic [5:0]          slot,
  input  wire logic [63:0]         now_ticks,
  input  wire logic                entry_present,
  input  wire logic [1:0]          entry_state,
  input  wire logic [7:0]          entry_counter,
  input  wire logic [6:0]          entry_priority,
  input  wire logic [63:0]         entry_timeout,
  input  wire logic [63:0]         entry_alarm,
  input  wire logic [31:0]         entry_signals,
  input  wire logic [31:0]         entry_blocked,
  output cpts_sts_t                sts,
  output logic [5:0]               best_slot,
  output logic [8:0]               best_count,
  output logic                     refilled,
  output logic [1:0]               rd_state,
  output logic [7:0]               rd_counter,
  output logic [31:0]              rd_signals,
  output logic [63:0]              rd_timeout,
  output logic [63:0]              rd_alarm
);

  logic        used    [NUM_SLOTS];
  logic [1:0]  mode    [NUM_SLOTS];
  logic [7:0]  slice   [NUM_SLOTS];
  logic [6:0]  prio    [NUM_SLOTS];
  logic [63:0] wake_dl [NUM_SLOTS];
  logic [63:0] alrm_dl [NUM_SLOTS];
  logic [31:0] pend    [NUM_SLOTS];
  logic [31:0] blkd    [NUM_SLOTS];

  logic [63:0] now_q;
  logic        in_range;
  logic [IW-1:0] sidx;
  logic [8:0]  cur_best;
  logic        wk_t, wk_a;
  logic [1:0]  mode_w;
  logic [31:0] pend_w;

  // Scan slot registered at idx, acted on in the cycle after.
  logic          q_used;
  logic [1:0]    q_mode;
  logic [7:0]    q_slice;
  logic [6:0]    q_prio;
  logic [63:0]   q_wake, q_alrm;
  logic [31:0]   q_pend, q_blkd;
  logic [IW-1:0] q_idx;
  logic          q_do_wake, q_do_pick, q_pick_init, q_do_refill;

  assign in_range = ({2'b0, slot} < 8'(NUM_SLOTS)) || (IW > 6);
  assign sidx     = IW'(slot);

  assign cur_best = q_pick_init ? 9'h1FF : best_count;

  always_ff @(posedge clk) begin
    q_used      <= used[idx];
    q_mode      <= mode[idx];
    q_slice     <= slice[idx];
    q_prio      <= prio[idx];
    q_wake      <= wake_dl[idx];
    q_alrm      <= alrm_dl[idx];
    q_pend      <= pend[idx];
    q_blkd      <= blkd[idx];
    q_idx       <= idx;
    q_do_wake   <= cmd.wake;
    q_do_pick   <= cmd.pick;
    q_pick_init <= cmd.pick_init;
    q_do_refill <= cmd.refill;
  end

  always_comb begin
    wk_t   = q_used && (q_wake != '0) && (q_wake < now_q);
    wk_a   = q_used && (q_alrm != '0) && (q_alrm < now_q);
    mode_w = (wk_t && q_mode == ST_INTR) ? ST_RUNNING : q_mode;
    pend_w = wk_a ? (q_pend | SIG_ALARM_BIT) : q_pend;
    if (q_used && mode_w == ST_INTR &&
        ((pend_w & ~(q_blkd & ~UNBLOCKABLE)) != '0)) begin
      mode_w = ST_RUNNING;
    end
  end

  assign sts.best_zero = (best_count == 9'd0);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      used[idx] <= 1'b0; mode[idx] <= '0; slice[idx] <= '0; prio[idx] <= '0;
      wake_dl[idx] <= '0; alrm_dl[idx] <= '0; pend[idx] <= '0; blkd[idx] <= '0;
    end
    if (cmd.write && in_range) begin
      used[sidx] <= entry_present; mode[sidx] <= entry_state;
      slice[sidx] <= entry_counter; prio[sidx] <= entry_priority;
      wake_dl[sidx] <= entry_timeout; alrm_dl[sidx] <= entry_alarm;
      pend[sidx] <= entry_signals; blkd[sidx] <= entry_blocked;
    end
    if (cmd.read) begin
      if (in_range) begin
        rd_state <= mode[sidx]; rd_counter <= slice[sidx];
        rd_signals <= pend[sidx]; rd_timeout <= wake_dl[sidx];
        rd_alarm <= alrm_dl[sidx];
      end else begin
        rd_state <= '0; rd_counter <= '0; rd_signals <= '0;
        rd_timeout <= '0; rd_alarm <= '0;
      end
    end
    if (cmd.sched_start) begin
      now_q    <= now_ticks;
      refilled <= 1'b0;
    end
    if (cmd.set_refill) begin
      refilled <= 1'b1;
    end
    if (q_do_wake) begin
      mode[q_idx] <= mode_w;
      pend[q_idx] <= pend_w;
      if (wk_t) wake_dl[q_idx] <= '0;
      if (wk_a) alrm_dl[q_idx] <= '0;
    end
    if (q_do_pick) begin
      if (q_used && q_mode == ST_RUNNING &&
          ($signed({1'b0, q_slice}) > $signed(cur_best))) begin
        best_count <= {1'b0, q_slice};
        best_slot  <= 6'(q_idx);
      end else if (q_pick_init) begin
        best_count <= 9'h1FF;
        best_slot  <= '0;
      end
    end
    if (q_do_refill && q_used) begin
      slice[q_idx] <= (q_slice >> 1) + {1'b0, q_prio};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/counter_priority_task_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_core: counter/priority task scheduler
// Slot table with write, read and schedule operations.
// ----------------------------------------------------------------------------
// Channel  | Dir | Contents
// s_axis   | in  | tdata: operation, slot, now_ticks, entry_present, entry_state,
//          |     |   entry_counter, entry_priority, entry_timeout, entry_alarm,
//          |     |   entry_signals, entry_blocked
// m_axis   | out | tdata: next_slot, chosen_count, refilled, read_state,
//          |     |   read_counter, read_signals, read_timeout, read_alarm;
//          |     |   tuser: result_kind
//
// A schedule runs a wake scan and a pick scan over all slots but slot 0 and
// a decision step before its result is valid; when the best counter found is
// zero, a refill scan and a rescan follow. A scan reads one slot a cycle and
// acts on it the cycle after.
// After reset a clearing pass over every slot runs with s_axis_tready low.
// A result waits in the output register; no new transfer is taken until it
// has left.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_core import cpts_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // operation, slot, now_ticks, entry_present, entry_state, entry_counter,
  // entry_priority, entry_timeout, entry_alarm, entry_signals, entry_blocked
  input  wire logic [IN_BITS-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // next_slot, chosen_count, refilled, read_state, read_counter,
  // read_signals, read_timeout, read_alarm
  output logic [OUT_BITS-1:0]       m_axis_tdata,
  // result_kind
  output logic                      m_axis_tuser
);

  localparam int IW = $clog2(NUM_SLOTS);

  cpts_cmd_t     cmd;
  cpts_sts_t     sts;
  logic [IW-1:0] idx;
  logic          in_fire, emit, kind;
  logic [5:0]    best_slot;
  logic [8:0]    best_count;
  logic          refilled;
  logic [1:0]    rd_state;
  logic [7:0]    rd_counter;
  logic [31:0]   rd_signals;
  logic [63:0]   rd_timeout, rd_alarm;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  cpts_ctrl #(.NUM_SLOTS(NUM_SLOTS), .IW(IW)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_axis_tdata[1:0]),
    .out_busy(m_axis_tvalid), .sts(sts), .cmd(cmd), .idx(idx),
    .in_ready(s_axis_tready), .emit(emit)
  );

  cpts_dp #(.NUM_SLOTS(NUM_SLOTS), .IW(IW)) u_dp (
    .clk(clk), .cmd(cmd), .idx(idx),
    .slot(s_axis_tdata[7:2]), .now_ticks(s_axis_tdata[71:8]),
    .entry_present(s_axis_tdata[72]), .entry_state(s_axis_tdata[74:73]),
    .entry_counter(s_axis_tdata[82:75]), .entry_priority(s_axis_tdata[89:83]),
    .entry_timeout(s_axis_tdata[153:90]), .entry_alarm(s_axis_tdata[217:154]),
    .entry_signals(s_axis_tdata[249:218]), .entry_blocked(s_axis_tdata[281:250]),
    .sts(sts), .best_slot(best_slot), .best_count(best_count),
    .refilled(refilled), .rd_state(rd_state), .rd_counter(rd_counter),
    .rd_signals(rd_signals), .rd_timeout(rd_timeout), .rd_alarm(rd_alarm)
  );

  // Result valid: raised in the cycle after emit (read data lands then too).
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      kind          <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
      kind          <= cmd.read;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Schedule results carry zero readback fields and vice versa.
  always_comb begin
    m_axis_tuser = kind;
    m_axis_tdata = '0;
    if (kind) begin
      m_axis_tdata[17:16]  = rd_state;
      m_axis_tdata[25:18]  = rd_counter;
      m_axis_tdata[57:26]  = rd_signals;
      m_axis_tdata[121:58] = rd_timeout;
      m_axis_tdata[185:122] = rd_alarm;
    end else begin
      m_axis_tdata[5:0]  = best_slot;
      m_axis_tdata[14:6] = best_count;
      m_axis_tdata[15]   = refilled;
    end
  end

endmodule
`default_nettype wire
